### hdl/nlc_pkg.sv
`timescale 1ns / 1ps
package nlc_pkg;

  // Field widths fixed by the port contract
  localparam int MAX_TOKEN_LEN = 64;
  localparam int LINE_BITS     = 16;
  localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 1);
  localparam int LIMIT_MIN     = 2;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_TOKEN_LEN);

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_D     = 8'h44;

  // Element letter codes
  localparam logic [2:0] LT_NONE = 3'd0;
  localparam logic [2:0] LT_V    = 3'd1;
  localparam logic [2:0] LT_R    = 3'd2;
  localparam logic [2:0] LT_I    = 3'd3;
  localparam logic [2:0] LT_C    = 3'd4;
  localparam logic [2:0] LT_L    = 3'd5;
  localparam logic [2:0] LT_D    = 3'd6;

  typedef enum logic [2:0] {
    CK_TOKEN,
    CK_SPACE,
    CK_STAR,
    CK_NEWLINE,
    CK_END
  } char_kind_t;

  // Classified character as it travels through the queue
  typedef struct packed {
    char_kind_t kind;
    logic       digit;
    logic       zero;
    logic       sign;
    logic       point;
    logic [2:0] letter;
  } char_class_t;

endpackage

### hdl/nlc_char_if.sv
`timescale 1ns / 1ps
interface nlc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_mark;

  modport source(output valid, output char_code, output end_mark, input ready);
  modport sink(input valid, input char_code, input end_mark, output ready);
endinterface

### hdl/nlc_result_if.sv
`timescale 1ns / 1ps
interface nlc_result_if;
  logic        valid;
  logic        ready;
  logic        is_element_id;
  logic [2:0]  element_letter;
  logic        is_unsigned;
  logic        is_decimal;
  logic        too_long;
  logic [6:0]  token_length;
  logic [15:0] start_line;
  logic        end_of_input;

  modport source(
    output valid, output is_element_id, output element_letter, output is_unsigned,
    output is_decimal, output too_long, output token_length, output start_line,
    output end_of_input, input ready
  );
  modport sink(
    input valid, input is_element_id, input element_letter, input is_unsigned,
    input is_decimal, input too_long, input token_length, input start_line,
    input end_of_input, output ready
  );
endinterface

### hdl/netlist_token_classifier.sv
`timescale 1ns / 1ps
// Netlist token classifier. Takes one character per transaction on
// char_stream (or an end mark) and returns one transaction on token_stream
// for every finished token and for each end mark, carrying the element-id,
// unsigned and decimal match flags, the too-long flag, the token length and
// its start line. Sustained rate is one character per clock cycle when not
// stalled: the front end classifies a character in the cycle it is accepted
// and pushes it into a queue of QUEUE_DEPTH entries; the back end pops one
// entry per cycle and advances the scanner state. A result is registered
// once the finishing character has passed the queue. A stalled token_stream
// holds the back end, and char_stream keeps being accepted until the queue fills.
// token_limit is written through cfg_wr_en / cfg_wr_data (7 bits, reset 64,
// clamped to 2..64) and must only change while the block is idle.
module netlist_token_classifier #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [nlc_pkg::CNT_W-1:0] cfg_wr_data,
  nlc_char_if.sink                  char_stream,
  nlc_result_if.source              token_stream
);
  import nlc_pkg::*;

  logic [CNT_W-1:0] token_limit;

  char_class_t push_data;
  char_class_t head_data;
  logic        push;
  logic        full;
  logic        pop;
  logic        head_valid;

  // Hold the limit register; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      token_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      token_limit <= cfg_wr_data;
    end
  end

  // Front end: accept and classify each character
  nlc_front u_front (
    .char_stream (char_stream),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  // Decouple the two sides so each can stall on its own
  nlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_data  (head_data),
    .head_valid (head_valid)
  );

  // Back end: run the scanner and drive the output register
  nlc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head_data),
    .pop          (pop),
    .token_limit  (token_limit),
    .token_stream (token_stream)
  );
endmodule

### hdl/nlc_front.sv
`timescale 1ns / 1ps
module nlc_front (
  nlc_char_if.sink            char_stream,
  input  logic                full,
  output logic                push,
  output nlc_pkg::char_class_t push_data
);
  import nlc_pkg::*;

  logic [7:0] c;

  assign c = char_stream.char_code;
  assign char_stream.ready = !full;
  assign push = char_stream.valid && !full;

  always_comb begin
    push_data.digit = (c >= CH_ZERO) && (c <= CH_NINE);
    push_data.zero  = (c == CH_ZERO);
    push_data.sign  = (c == CH_PLUS) || (c == CH_MINUS);
    push_data.point = (c == CH_POINT);

    unique case (c)
      CH_V:    push_data.letter = LT_V;
      CH_R:    push_data.letter = LT_R;
      CH_I:    push_data.letter = LT_I;
      CH_C:    push_data.letter = LT_C;
      CH_L:    push_data.letter = LT_L;
      CH_D:    push_data.letter = LT_D;
      default: push_data.letter = LT_NONE;
    endcase

    // End mark wins over any character byte
    priority if (char_stream.end_mark) begin
      push_data.kind = CK_END;
    end else if (c == CH_NL) begin
      push_data.kind = CK_NEWLINE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      push_data.kind = CK_SPACE;
    end else if (c == CH_STAR) begin
      push_data.kind = CK_STAR;
    end else begin
      push_data.kind = CK_TOKEN;
    end
  end
endmodule

### hdl/nlc_queue.sv
`timescale 1ns / 1ps
module nlc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  nlc_pkg::char_class_t push_data,
  output logic                 full,
  input  logic                 pop,
  output nlc_pkg::char_class_t head_data,
  output logic                 head_valid
);
  import nlc_pkg::*;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  char_class_t        slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full       = (count == COUNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

### hdl/nlc_back.sv
`timescale 1ns / 1ps
module nlc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  nlc_pkg::char_class_t         head,
  output logic                         pop,
  input  logic [nlc_pkg::CNT_W-1:0]    token_limit,
  nlc_result_if.source                 token_stream
);
  import nlc_pkg::*;

  typedef enum logic [1:0] {U_START, U_ZERO, U_NUM, U_FAIL} uint_state_t;
  typedef enum logic [2:0] {D_START, D_SIGN, D_INT, D_FRAC, D_FAIL} dec_state_t;

  typedef struct packed {
    logic                 is_element_id;
    logic [2:0]           element_letter;
    logic                 is_unsigned;
    logic                 is_decimal;
    logic                 too_long;
    logic [CNT_W-1:0]     token_length;
    logic [LINE_BITS-1:0] start_line;
    logic                 end_of_input;
  } result_t;

  function automatic uint_state_t uint_next(uint_state_t s, char_class_t k);
    uint_state_t r;
    r = U_FAIL;
    if (s == U_START) begin
      if (k.zero) r = U_ZERO;
      else if (k.digit) r = U_NUM;
    end else if (s == U_NUM && k.digit) begin
      r = U_NUM;
    end
    return r;
  endfunction

  function automatic dec_state_t dec_next(dec_state_t s, char_class_t k);
    dec_state_t r;
    r = D_FAIL;
    unique case (s)
      D_START: begin
        if (k.sign) r = D_SIGN;
        else if (k.digit) r = D_INT;
        else if (k.point) r = D_FRAC;
      end
      D_SIGN: if (k.digit) r = D_INT;
      D_INT: begin
        if (k.digit) r = D_INT;
        else if (k.point) r = D_FRAC;
      end
      D_FRAC: if (k.digit) r = D_FRAC;
      default: r = D_FAIL;
    endcase
    return r;
  endfunction

  // Scanner state
  dec_state_t           pattern_state, pattern_state_next;
  uint_state_t          uint_state, uint_state_next;
  uint_state_t          elem_state, elem_state_next;
  logic [2:0]           letter_seen, letter_seen_next;
  logic [CNT_W-1:0]     token_count, token_count_next;
  logic                 in_comment, in_comment_next;
  logic [LINE_BITS-1:0] line_number, line_number_next;
  logic [LINE_BITS-1:0] token_line, token_line_next;

  // Output register
  logic    res_valid;
  result_t res;
  result_t emit_res;
  logic    do_emit;

  logic [CNT_W-1:0] lim;
  logic             tl;
  logic             el;
  logic             open_token;

  assign pop = head_valid && (!res_valid || token_stream.ready);
  assign open_token = (token_count != '0);

  // Clamp the limit register into its legal range
  always_comb begin
    if (token_limit < CNT_W'(LIMIT_MIN)) lim = CNT_W'(LIMIT_MIN);
    else if (token_limit > CNT_W'(MAX_TOKEN_LEN)) lim = CNT_W'(MAX_TOKEN_LEN);
    else lim = token_limit;
  end

  assign tl = (token_count >= lim);
  assign el = !tl && (letter_seen != LT_NONE) && (elem_state != U_FAIL);

  always_comb begin
    emit_res.is_element_id  = el;
    emit_res.element_letter = el ? letter_seen : LT_NONE;
    emit_res.is_unsigned    = !tl && (uint_state == U_ZERO || uint_state == U_NUM);
    emit_res.is_decimal     = !tl && (pattern_state == D_INT || pattern_state == D_FRAC);
    emit_res.too_long       = tl;
    emit_res.token_length   = (token_count > lim) ? lim : token_count;
    emit_res.start_line     = (head.kind == CK_END && !open_token) ? line_number : token_line;
    emit_res.end_of_input   = (head.kind == CK_END);
  end

  always_comb begin
    pattern_state_next = pattern_state;
    uint_state_next    = uint_state;
    elem_state_next    = elem_state;
    letter_seen_next   = letter_seen;
    token_count_next   = token_count;
    in_comment_next    = in_comment;
    line_number_next   = line_number;
    token_line_next    = token_line;
    do_emit            = 1'b0;

    unique case (head.kind)
      CK_END: begin
        do_emit            = 1'b1;
        pattern_state_next = D_START;
        uint_state_next    = U_START;
        elem_state_next    = U_FAIL;
        letter_seen_next   = LT_NONE;
        token_count_next   = '0;
        in_comment_next    = 1'b0;
        line_number_next   = LINE_BITS'(1);
        token_line_next    = LINE_BITS'(1);
      end
      CK_NEWLINE: begin
        do_emit          = open_token;
        token_count_next = '0;
        in_comment_next  = 1'b0;
        if (line_number != '1) line_number_next = line_number + 1'b1;
      end
      CK_SPACE, CK_STAR: begin
        if (!in_comment) begin
          do_emit          = open_token;
          token_count_next = '0;
          if (head.kind == CK_STAR) in_comment_next = 1'b1;
        end
      end
      CK_TOKEN: begin
        if (!in_comment) begin
          if (!open_token) begin
            token_line_next    = line_number;
            letter_seen_next   = head.letter;
            elem_state_next    = (head.letter != LT_NONE) ? U_START : U_FAIL;
            pattern_state_next = dec_next(D_START, head);
            uint_state_next    = uint_next(U_START, head);
          end else begin
            if (letter_seen != LT_NONE) elem_state_next = uint_next(elem_state, head);
            pattern_state_next = dec_next(pattern_state, head);
            uint_state_next    = uint_next(uint_state, head);
          end
          if (token_count < CNT_W'(MAX_TOKEN_LEN)) token_count_next = token_count + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_state <= D_START;
      uint_state    <= U_START;
      elem_state    <= U_FAIL;
      letter_seen   <= LT_NONE;
      token_count   <= '0;
      in_comment    <= 1'b0;
      line_number   <= LINE_BITS'(1);
      token_line    <= LINE_BITS'(1);
      res_valid     <= 1'b0;
    end else begin
      if (pop) begin
        pattern_state <= pattern_state_next;
        uint_state    <= uint_state_next;
        elem_state    <= elem_state_next;
        letter_seen   <= letter_seen_next;
        token_count   <= token_count_next;
        in_comment    <= in_comment_next;
        line_number   <= line_number_next;
        token_line    <= token_line_next;
      end
      if (pop && do_emit) begin
        res_valid <= 1'b1;
        res       <= emit_res;
      end else if (token_stream.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign token_stream.valid          = res_valid;
  assign token_stream.is_element_id  = res.is_element_id;
  assign token_stream.element_letter = res.element_letter;
  assign token_stream.is_unsigned    = res.is_unsigned;
  assign token_stream.is_decimal     = res.is_decimal;
  assign token_stream.too_long       = res.too_long;
  assign token_stream.token_length   = res.token_length;
  assign token_stream.start_line     = res.start_line;
  assign token_stream.end_of_input   = res.end_of_input;
endmodule

### hdl/nlc_checker.sv
`timescale 1ns / 1ps
module nlc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_element_id,
  input logic [2:0] element_letter,
  input logic       is_unsigned,
  input logic       is_decimal,
  input logic       too_long
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid) && !$past(out_ready) && !$past(rst)) |-> out_valid)
    else $error("result dropped while stalled");

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_letter_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_element_id == (element_letter != 3'd0)))
    else $error("element letter inconsistent with element flag");

  a_too_long_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_long) |-> (!is_element_id && !is_unsigned && !is_decimal))
    else $error("match flag set on too-long token");

endmodule

bind netlist_token_classifier nlc_checker u_nlc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (token_stream.valid),
  .out_ready      (token_stream.ready),
  .is_element_id  (token_stream.is_element_id),
  .element_letter (token_stream.element_letter),
  .is_unsigned    (token_stream.is_unsigned),
  .is_decimal     (token_stream.is_decimal),
  .too_long       (token_stream.too_long)
);
